// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the tilt unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, sampled on clk, off during reset.
`define ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication, sampled on clk, off during reset.
`define ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, ante, cons)
`define ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/ioc_pkg.sv =====
// Types, constants and the arctangent table of the tilt unit.
package ioc_pkg;
	localparam int SAMPLE_BITS  = 16;
	localparam int CORDIC_STEPS = 16;
	localparam int TABLE_LEN    = 24;
	localparam int FRAC         = 32 - SAMPLE_BITS;
	localparam int SUM_BITS     = 2 * SAMPLE_BITS;
	localparam int RAD_BITS     = SUM_BITS + 2 * FRAC;
	localparam int ROOT_BITS    = RAD_BITS / 2;
	localparam int NUM_BITS     = SAMPLE_BITS + 1;
	localparam int CORDIC_N     = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
	localparam int XY_BITS      = ROOT_BITS + 16;
	localparam int Z_BITS       = 26;
	localparam int ANGLE_BITS   = 15;
	localparam int ANGLE_LIMIT  = 11520;
	localparam int NUM_REGS     = 6;
	localparam int IDX_BITS     = 3;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [NUM_BITS-1:0]    num_t;
	typedef logic        [SUM_BITS-1:0]    sum_t;
	typedef logic        [RAD_BITS-1:0]    rad_t;
	typedef logic        [ROOT_BITS-1:0]   root_t;
	typedef logic signed [XY_BITS-1:0]     xy_t;
	typedef logic signed [Z_BITS-1:0]      z_t;
	typedef logic signed [ANGLE_BITS-1:0]  angle_t;

	typedef struct packed {
		logic adv;
		logic valid;
	} pipe_ctl_t;

	// atan(2^-i) in 1/32768 degree
	function automatic z_t atan_entry(input int i);
		logic [20:0] t;
		case (i)
			0:  t = 21'd1474560;
			1:  t = 21'd870484;
			2:  t = 21'd459940;
			3:  t = 21'd233473;
			4:  t = 21'd117189;
			5:  t = 21'd58652;
			6:  t = 21'd29333;
			7:  t = 21'd14667;
			8:  t = 21'd7334;
			9:  t = 21'd3667;
			10: t = 21'd1833;
			11: t = 21'd917;
			12: t = 21'd458;
			13: t = 21'd229;
			14: t = 21'd115;
			15: t = 21'd57;
			16: t = 21'd29;
			17: t = 21'd14;
			18: t = 21'd7;
			19: t = 21'd4;
			20: t = 21'd2;
			21: t = 21'd1;
			default: t = 21'd0;
		endcase
		return z_t'(t);
	endfunction
endpackage

// ===== hw/rtl/imu_offset_correct_and_tilt_unit.sv =====
// Top level: offset correction, two tilt lanes (roll, pitch) and the merge stage.
//
//  channel | handshake            | words
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_ready  | gyro_x..z, accel_x..z
//  out     | out_valid / out_ready| rate_x..z, force_x..z, roll/pitch, undefined
//  cfg     | cfg_we               | cfg_index, cfg_data (offsets 0..5)
//
// One word per cycle while the pipeline does not hold; the square root resolves one
// result bit per stage and the CORDIC does one iteration per stage.
// The whole pipeline holds only when the output register is full and not taken
// while the last stage carries a word; while the last stage is empty, the stages keep filling.
// Reset clears the valid bits and the offsets; no clearing pass.
`include "assert_macros.svh"
module imu_offset_correct_and_tilt_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [ioc_pkg::IDX_BITS-1:0] cfg_index,
	input  ioc_pkg::sample_t             cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  ioc_pkg::sample_t             gyro_x,
	input  ioc_pkg::sample_t             gyro_y,
	input  ioc_pkg::sample_t             gyro_z,
	input  ioc_pkg::sample_t             accel_x,
	input  ioc_pkg::sample_t             accel_y,
	input  ioc_pkg::sample_t             accel_z,
	output logic                         out_valid,
	input  logic                         out_ready,
	output ioc_pkg::sample_t             rate_x,
	output ioc_pkg::sample_t             rate_y,
	output ioc_pkg::sample_t             rate_z,
	output ioc_pkg::sample_t             force_x,
	output ioc_pkg::sample_t             force_y,
	output ioc_pkg::sample_t             force_z,
	output ioc_pkg::angle_t              roll_angle,
	output ioc_pkg::angle_t              pitch_angle,
	output logic                         angle_undefined
);
	localparam int NR  = ioc_pkg::NUM_REGS;
	localparam int LAT = 1 + ioc_pkg::ROOT_BITS + ioc_pkg::CORDIC_N;
	localparam int SB  = ioc_pkg::SAMPLE_BITS;

	ioc_pkg::sample_t off_q [NR];
	ioc_pkg::sample_t raw   [NR];
	ioc_pkg::sample_t c_s1  [NR];
	ioc_pkg::sample_t dly_s [LAT+1][NR];
	logic             v_s1, v_s2;
	ioc_pkg::sum_t    sxz_s2, syz_s2;
	ioc_pkg::num_t    nr_s2, np_s2;
	logic             adv, v_last, out_valid_q;
	ioc_pkg::pipe_ctl_t ctl_s2, ctl_sq;

	// offsets
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NR; i++) off_q[i] <= '0;
		end else if (cfg_we && (cfg_index < ioc_pkg::IDX_BITS'(NR))) begin
			off_q[cfg_index] <= cfg_data;
		end
	end

	assign raw[0] = gyro_x;
	assign raw[1] = gyro_y;
	assign raw[2] = gyro_z;
	assign raw[3] = accel_x;
	assign raw[4] = accel_y;
	assign raw[5] = accel_z;

	assign adv      = out_ready || !out_valid_q || !v_last;
	assign in_ready = adv;

	// stage 1: subtract and saturate, one lane per axis
	for (genvar a = 0; a < NR; a++) begin : g_corr
		logic signed [SB:0] diff;
		ioc_pkg::sample_t   sat;
		always_comb begin
			diff = (SB+1)'(raw[a]) - (SB+1)'(off_q[a]);
			if (diff[SB] != diff[SB-1])
				sat = diff[SB] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
			else
				sat = diff[SB-1:0];
		end
		always_ff @(posedge clk) begin
			if (adv) c_s1[a] <= sat;
		end
	end

	// stage 2: sums of squares and numerators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid && in_ready;
			v_s2 <= v_s1;
		end
	end

	logic [ioc_pkg::SUM_BITS-1:0] sq_x, sq_y, sq_z;
	always_comb begin
		sq_x = ioc_pkg::SUM_BITS'($signed(c_s1[3]) * $signed(c_s1[3]));
		sq_y = ioc_pkg::SUM_BITS'($signed(c_s1[4]) * $signed(c_s1[4]));
		sq_z = ioc_pkg::SUM_BITS'($signed(c_s1[5]) * $signed(c_s1[5]));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sxz_s2 <= sq_x + sq_z;
			syz_s2 <= sq_y + sq_z;
			nr_s2  <= ioc_pkg::num_t'(c_s1[4]);
			np_s2  <= -ioc_pkg::num_t'(c_s1[3]);
		end
	end

	// corrected samples ride along to the merge stage
	for (genvar d = 0; d < NR; d++) begin : g_dly
		assign dly_s[0][d] = c_s1[d];
		for (genvar k = 0; k < LAT; k++) begin : g_tap
			always_ff @(posedge clk) begin
				if (adv) dly_s[k+1][d] <= dly_s[k][d];
			end
		end
	end

	assign ctl_s2 = '{adv: adv, valid: v_s2};

	logic           vr_rt, vp_rt, vr_cd, vp_cd;
	ioc_pkg::root_t dr, dp;
	ioc_pkg::num_t  nr_rt, np_rt;
	ioc_pkg::z_t    zr, zp;
	logic           r_dz, r_pos, r_nz, p_dz, p_pos, p_nz;

	ioc_sqrt u_sqrt_roll (
		.clk(clk), .arst_n(arst_n), .ctl(ctl_s2),
		.radicand({sxz_s2, {(2*ioc_pkg::FRAC){1'b0}}}), .num_in(nr_s2),
		.valid_out(vr_rt), .root(dr), .num_out(nr_rt)
	);
	ioc_sqrt u_sqrt_pitch (
		.clk(clk), .arst_n(arst_n), .ctl(ctl_s2),
		.radicand({syz_s2, {(2*ioc_pkg::FRAC){1'b0}}}), .num_in(np_s2),
		.valid_out(vp_rt), .root(dp), .num_out(np_rt)
	);

	assign ctl_sq = '{adv: adv, valid: vr_rt};

	ioc_cordic u_cordic_roll (
		.clk(clk), .arst_n(arst_n), .ctl(ctl_sq), .root(dr), .num_in(nr_rt),
		.valid_out(vr_cd), .z_out(zr), .den_zero(r_dz), .num_pos(r_pos), .num_zero(r_nz)
	);
	ioc_cordic u_cordic_pitch (
		.clk(clk), .arst_n(arst_n), .ctl('{adv: adv, valid: vp_rt}), .root(dp),
		.num_in(np_rt), .valid_out(vp_cd), .z_out(zp), .den_zero(p_dz),
		.num_pos(p_pos), .num_zero(p_nz)
	);

	assign v_last = vr_cd;

	// merge: round, clamp, special cases
	function automatic ioc_pkg::angle_t finish(input ioc_pkg::z_t z, input logic dz,
		input logic pos, input logic nz);
		ioc_pkg::z_t r;
		ioc_pkg::z_t lim;
		r   = (z + ioc_pkg::z_t'(128)) >>> 8;
		lim = ioc_pkg::z_t'(ioc_pkg::ANGLE_LIMIT);
		if (dz) begin
			if (nz)       r = '0;
			else if (pos) r = lim;
			else          r = -lim;
		end else if (r > lim) begin
			r = lim;
		end else if (r < -lim) begin
			r = -lim;
		end
		return r[ioc_pkg::ANGLE_BITS-1:0];
	endfunction

	ioc_pkg::sample_t res_q [NR];
	ioc_pkg::angle_t  roll_q, pitch_q;
	logic             undef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready || !out_valid_q) begin
			out_valid_q <= v_last;
		end
	end

	always_ff @(posedge clk) begin
		if (v_last && (out_ready || !out_valid_q)) begin
			for (int i = 0; i < NR; i++) res_q[i] <= dly_s[LAT][i];
			roll_q  <= finish(zr, r_dz, r_pos, r_nz);
			pitch_q <= finish(zp, p_dz, p_pos, p_nz);
			undef_q <= (r_dz && r_nz) || (p_dz && p_nz);
		end
	end

	assign out_valid       = out_valid_q;
	assign rate_x          = res_q[0];
	assign rate_y          = res_q[1];
	assign rate_z          = res_q[2];
	assign force_x         = res_q[3];
	assign force_y         = res_q[4];
	assign force_z         = res_q[5];
	assign roll_angle      = roll_q;
	assign pitch_angle     = pitch_q;
	assign angle_undefined = undef_q;

	`ASSERT_IMP(a_lanes_aligned, 1'b1, vr_cd == vp_cd)
	`ASSERT_IMP(a_stall_only_full, !in_ready, out_valid && !out_ready && v_last)
	`ASSERT_IMP(a_undef_zero, out_valid && angle_undefined, roll_angle == 0 && pitch_angle == 0 && force_x == 0 && force_y == 0 && force_z == 0)
	`ASSERT_IMP(a_roll_range, out_valid, $signed(roll_angle) <= 15'sd11520 && $signed(roll_angle) >= -15'sd11520)
endmodule

// ===== hw/rtl/ioc_sqrt.sv =====
// Pipelined integer square root, one result bit per stage, with a side numerator.
module ioc_sqrt (
	input  logic              clk,
	input  logic              arst_n,
	input  ioc_pkg::pipe_ctl_t ctl,
	input  ioc_pkg::rad_t     radicand,
	input  ioc_pkg::num_t     num_in,
	output logic              valid_out,
	output ioc_pkg::root_t    root,
	output ioc_pkg::num_t     num_out
);
	localparam int N = ioc_pkg::ROOT_BITS;

	logic                 vld_s  [N+1];
	ioc_pkg::rad_t        rem_s  [N+1];
	ioc_pkg::root_t       root_s [N+1];
	ioc_pkg::num_t        num_s  [N+1];

	assign vld_s[0]  = ctl.valid;
	assign rem_s[0]  = radicand;
	assign root_s[0] = '0;
	assign num_s[0]  = num_in;

	for (genvar g = 0; g < N; g++) begin : g_stage
		localparam int B = N - 1 - g;
		logic [ioc_pkg::RAD_BITS:0] trial;
		logic                       take;
		always_comb begin
			trial = ((ioc_pkg::RAD_BITS + 1)'(root_s[g]) << (B + 1))
				+ ((ioc_pkg::RAD_BITS + 1)'(1) << (2 * B));
			take  = {1'b0, rem_s[g]} >= trial;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (ctl.adv) begin
				vld_s[g+1] <= vld_s[g];
			end
		end
		always_ff @(posedge clk) begin
			if (ctl.adv) begin
				num_s[g+1] <= num_s[g];
				if (take) begin
					rem_s[g+1]  <= rem_s[g] - trial[ioc_pkg::RAD_BITS-1:0];
					root_s[g+1] <= root_s[g] | (ioc_pkg::ROOT_BITS'(1) << B);
				end else begin
					rem_s[g+1]  <= rem_s[g];
					root_s[g+1] <= root_s[g];
				end
			end
		end
	end

	assign valid_out = vld_s[N];
	assign root      = root_s[N];
	assign num_out   = num_s[N];
endmodule

// ===== hw/rtl/ioc_cordic.sv =====
// Pipelined vectoring CORDIC: angle of (root, numerator), one iteration per stage.
module ioc_cordic (
	input  logic              clk,
	input  logic              arst_n,
	input  ioc_pkg::pipe_ctl_t ctl,
	input  ioc_pkg::root_t    root,
	input  ioc_pkg::num_t     num_in,
	output logic              valid_out,
	output ioc_pkg::z_t       z_out,
	output logic              den_zero,
	output logic              num_pos,
	output logic              num_zero
);
	localparam int N = ioc_pkg::CORDIC_N;

	logic          vld_s [N+1];
	ioc_pkg::xy_t  x_s   [N+1];
	ioc_pkg::xy_t  y_s   [N+1];
	ioc_pkg::z_t   z_s   [N+1];
	logic [2:0]    flg_s [N+1];

	assign vld_s[0] = ctl.valid;
	assign x_s[0]   = ioc_pkg::xy_t'({root, 8'b0});
	assign y_s[0]   = ioc_pkg::xy_t'(num_in) <<< (ioc_pkg::FRAC + 8);
	assign z_s[0]   = '0;
	assign flg_s[0] = {root == '0, ~num_in[ioc_pkg::NUM_BITS-1] && (num_in != '0),
		num_in == '0};

	for (genvar g = 0; g < N; g++) begin : g_stage
		ioc_pkg::xy_t dx, dy;
		assign dx = x_s[g] >>> g;
		assign dy = y_s[g] >>> g;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (ctl.adv) begin
				vld_s[g+1] <= vld_s[g];
			end
		end
		always_ff @(posedge clk) begin
			if (ctl.adv) begin
				flg_s[g+1] <= flg_s[g];
				// rotate toward y = 0
				if (!y_s[g][ioc_pkg::XY_BITS-1]) begin
					x_s[g+1] <= x_s[g] + dy;
					y_s[g+1] <= y_s[g] - dx;
					z_s[g+1] <= z_s[g] + ioc_pkg::atan_entry(g);
				end else begin
					x_s[g+1] <= x_s[g] - dy;
					y_s[g+1] <= y_s[g] + dx;
					z_s[g+1] <= z_s[g] - ioc_pkg::atan_entry(g);
				end
			end
		end
	end

	assign valid_out = vld_s[N];
	assign z_out     = z_s[N];
	assign den_zero  = flg_s[N][2];
	assign num_pos   = flg_s[N][1];
	assign num_zero  = flg_s[N][0];
endmodule

// ===== sim/tb_top.sv =====
// Testbench for the IMU offset correction and tilt unit: random and directed samples.
`timescale 1ns / 1ps
module tb_top;
	localparam int IDX_GYRO_X  = 0;
	localparam int IDX_GYRO_Y  = 1;
	localparam int IDX_GYRO_Z  = 2;
	localparam int IDX_ACCEL_X = 3;
	localparam int IDX_ACCEL_Y = 4;
	localparam int IDX_ACCEL_Z = 5;
	localparam int IDX_UNUSED  = 7;
	localparam int LATENCY     = 51;
	localparam int WATCHDOG    = 5000;

	typedef struct packed {
		logic signed [15:0] rx, ry, rz, fx, fy, fz;
		logic signed [14:0] roll, pitch;
		logic               undef;
	} tilt_word_t;

	logic clk = 0, arst_n = 0;
	logic cfg_we = 0;
	logic [ioc_pkg::IDX_BITS-1:0] cfg_index = '0;
	ioc_pkg::sample_t cfg_data = '0;
	logic in_valid = 0, in_ready;
	ioc_pkg::sample_t gyro_x = '0, gyro_y = '0, gyro_z = '0;
	ioc_pkg::sample_t accel_x = '0, accel_y = '0, accel_z = '0;
	logic out_valid, out_ready = 0;
	ioc_pkg::sample_t rate_x, rate_y, rate_z, force_x, force_y, force_z;
	ioc_pkg::angle_t roll_angle, pitch_angle;
	logic angle_undefined;

	imu_offset_correct_and_tilt_unit dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	longint offs [6];
	tilt_word_t tilt_expected [$];
	int errors = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	int stall_mode = 0;

	function automatic longint fshift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint isqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return longint'(r);
	endfunction

	function automatic longint tilt_of(longint num, longint unsigned ss, ref bit undef);
		longint d, x, y, z, dx, dy, r;
		longint tab [24] = '{1474560, 870484, 459940, 233473, 117189, 58652, 29333,
			14667, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0, 0};
		d = isqrt(ss << 32);
		if (d == 0) begin
			if (num > 0) return ioc_pkg::ANGLE_LIMIT;
			if (num < 0) return -ioc_pkg::ANGLE_LIMIT;
			undef = 1;
			return 0;
		end
		x = d * 256;
		y = num * (64'sd1 <<< 24);
		z = 0;
		for (int i = 0; i < ioc_pkg::CORDIC_N; i++) begin
			dx = fshift(x, i);
			dy = fshift(y, i);
			if (y >= 0) begin
				x += dy; y -= dx; z += tab[i];
			end else begin
				x -= dy; y += dx; z -= tab[i];
			end
		end
		r = fshift(z + 128, 8);
		if (r > ioc_pkg::ANGLE_LIMIT) r = ioc_pkg::ANGLE_LIMIT;
		if (r < -ioc_pkg::ANGLE_LIMIT) r = -ioc_pkg::ANGLE_LIMIT;
		return r;
	endfunction

	function automatic tilt_word_t predict_tilt(ioc_pkg::sample_t s [6]);
		longint c [6];
		bit undef;
		tilt_word_t w;
		undef = 0;
		for (int i = 0; i < 6; i++) begin
			c[i] = longint'(s[i]) - offs[i];
			if (c[i] > 32767) c[i] = 32767;
			if (c[i] < -32768) c[i] = -32768;
		end
		w.rx = 16'(c[0]); w.ry = 16'(c[1]); w.rz = 16'(c[2]);
		w.fx = 16'(c[3]); w.fy = 16'(c[4]); w.fz = 16'(c[5]);
		w.roll = 15'(tilt_of(c[4], c[3] * c[3] + c[5] * c[5], undef));
		w.pitch = 15'(tilt_of(-c[3], c[4] * c[4] + c[5] * c[5], undef));
		w.undef = undef;
		return w;
	endfunction

	// one write, then cfg_we drops before the task returns, so back-to-back writes never collide
	task automatic write_offset(int idx, ioc_pkg::sample_t v);
		cfg_we <= 1;
		cfg_index <= ioc_pkg::IDX_BITS'(idx);
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
		if (idx < ioc_pkg::NUM_REGS) offs[idx] = longint'(v);
		@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (tilt_expected.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// send one sample word; with pace set, bursts and gaps on the sender side
	task automatic send_sample(ioc_pkg::sample_t s [6], bit pace);
		int gap;
		if (pace && burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid <= 0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		in_valid <= 1;
		gyro_x <= s[0]; gyro_y <= s[1]; gyro_z <= s[2];
		accel_x <= s[3]; accel_y <= s[4]; accel_z <= s[5];
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		tilt_expected.push_back(predict_tilt(s));
		if (burst_left > 0) burst_left--;
	endtask

	task automatic send_axes(int g0, int g1, int g2, int a0, int a1, int a2);
		ioc_pkg::sample_t s [6];
		s = '{ioc_pkg::sample_t'(g0), ioc_pkg::sample_t'(g1), ioc_pkg::sample_t'(g2),
			ioc_pkg::sample_t'(a0), ioc_pkg::sample_t'(a1), ioc_pkg::sample_t'(a2)};
		send_sample(s, 0);
	endtask

	function automatic ioc_pkg::sample_t rand_field(int mode);
		case (mode)
			0: return ioc_pkg::sample_t'($urandom);
			1: return ioc_pkg::sample_t'($urandom_range(0, 8192)) - 16'sd4096;
			2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			default: return ioc_pkg::sample_t'($urandom_range(0, 6)) - 16'sd3;
		endcase
	endfunction

	task automatic test_directed();
		send_axes(0, 0, 0, 0, 0, 0);
		send_axes(32767, -32768, 1, 32767, 32767, 32767);
		send_axes(-32768, 32767, -1, -32768, -32768, -32768);
		send_axes(1, 2, 3, 0, 4096, 0);
		send_axes(1, 2, 3, 0, -4096, 0);
		send_axes(0, 0, 0, 4096, 0, 0);
		send_axes(0, 0, 0, -4096, 0, 0);
		send_axes(0, 0, 0, 0, 0, 4096);
		send_axes(0, 0, 0, 0, 0, -1);
		send_axes(0, 0, 0, 4096, 4096, 0);
		send_axes(0, 0, 0, 1, 1, 1);
		send_axes(-1, -1, -1, -1, -1, -1);
		send_axes(100, -100, 0, 2896, 2896, 2896);
		send_axes(0, 0, 0, -32768, 32767, 0);
		drain();
	endtask

	// saturation both ways with offsets at the extremes
	task automatic test_offsets_extreme();
		write_offset(IDX_GYRO_X, 16'sh7fff);
		write_offset(IDX_GYRO_Y, 16'sh8000);
		write_offset(IDX_GYRO_Z, 16'sh7fff);
		write_offset(IDX_ACCEL_X, 16'sh8000);
		write_offset(IDX_ACCEL_Y, 16'sh7fff);
		write_offset(IDX_ACCEL_Z, 16'sh8000);
		write_offset(IDX_UNUSED, 16'sh1234);
		send_axes(-32768, 32767, -32768, 32767, -32768, 32767);
		send_axes(32767, -32768, 32767, -32768, 32767, -32768);
		send_axes(0, 0, 0, 0, 0, 0);
		send_axes(-32768, 32767, -32768, -32768, 32767, -32768);
		drain();
		write_offset(IDX_ACCEL_X, 16'sd100);
		write_offset(IDX_ACCEL_Y, -16'sd50);
		write_offset(IDX_ACCEL_Z, 16'sd7);
		// corrected accel of all zero
		send_axes(5, 5, 5, 100, -50, 7);
		send_axes(5, 5, 5, 101, -50, 7);
		drain();
	endtask

	task automatic test_random(int n);
		ioc_pkg::sample_t s [6];
		int mode;
		for (int k = 0; k < n; k++) begin
			mode = $urandom_range(0, 9);
			mode = (mode < 5) ? 0 : (mode < 7) ? 1 : (mode < 8) ? 2 : 3;
			foreach (s[i]) s[i] = rand_field(mode);
			if (mode == 3 && offs[5] == 0 && $urandom_range(0, 3) == 0) s[5] = 0;
			send_sample(s, 1);
		end
	endtask

	task automatic test_random_phases();
		for (int ph = 0; ph < 4; ph++) begin
			for (int r = 0; r < ioc_pkg::NUM_REGS; r++)
				write_offset(r, ph == 0 ? 16'sd0 : ph == 1 ? ioc_pkg::sample_t'($urandom)
					: ioc_pkg::sample_t'($urandom_range(0, 400)) - 16'sd200);
			write_offset(IDX_UNUSED, ioc_pkg::sample_t'($urandom));
			test_random(250);
			drain();
		end
	endtask

	// receiver stall pattern
	always @(posedge clk) begin
		if (stall_mode == 0) out_ready <= 1;
		else if (stall_mode == 1) out_ready <= ($urandom_range(0, 3) != 0);
		else out_ready <= ($urandom_range(0, 9) < 3);
		if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 2);
	end

	always @(posedge clk) begin
		tilt_word_t exp_w;
		if (arst_n && out_valid && out_ready) begin
			if (tilt_expected.size() == 0) begin
				$error("unexpected result word");
				errors++;
			end else begin
				exp_w = tilt_expected.pop_front();
				if (rate_x !== exp_w.rx) begin
					$error("rate_x exp %0d got %0d", exp_w.rx, rate_x); errors++;
				end
				if (rate_y !== exp_w.ry) begin
					$error("rate_y exp %0d got %0d", exp_w.ry, rate_y); errors++;
				end
				if (rate_z !== exp_w.rz) begin
					$error("rate_z exp %0d got %0d", exp_w.rz, rate_z); errors++;
				end
				if (force_x !== exp_w.fx) begin
					$error("force_x exp %0d got %0d", exp_w.fx, force_x); errors++;
				end
				if (force_y !== exp_w.fy) begin
					$error("force_y exp %0d got %0d", exp_w.fy, force_y); errors++;
				end
				if (force_z !== exp_w.fz) begin
					$error("force_z exp %0d got %0d", exp_w.fz, force_z); errors++;
				end
				if (roll_angle !== exp_w.roll) begin
					$error("roll_angle exp %0d got %0d", exp_w.roll, roll_angle); errors++;
				end
				if (pitch_angle !== exp_w.pitch) begin
					$error("pitch_angle exp %0d got %0d", exp_w.pitch, pitch_angle); errors++;
				end
				if (angle_undefined !== exp_w.undef) begin
					$error("angle_undefined exp %0d got %0d", exp_w.undef, angle_undefined);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		foreach (offs[i]) offs[i] = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_offsets_extreme();
		test_random_phases();
		drain();
		if (errors == 0 && tilt_expected.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
